// File: hw/rtl/dqe_pkg.sv
// dqe_pkg: shared types and constants of the double-ended queue
// no dependencies; imported by the interfaces, dqe_cell, double_ended_queue and tb_double_ended_queue

package dqe_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned STS_W = 2;
  localparam int unsigned OCC_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_READ_FWD  = 3'd4,
    CMD_READ_BWD  = 3'd5
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_ROT_FWD   = 3'd4,
    OP_ROT_BWD   = 3'd5
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

endpackage

// File: hw/rtl/dqe_cmd_if.sv
// dqe_cmd_if: command channel of the double-ended queue
// depends on dqe_pkg for field widths

interface dqe_cmd_if
  import dqe_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// File: hw/rtl/dqe_rsp_if.sv
// dqe_rsp_if: result channel of the double-ended queue
// depends on dqe_pkg for field widths

interface dqe_rsp_if
  import dqe_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] entry_value;
  logic                    is_last;
  logic [STS_W-1:0]        status;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, output entry_value, output is_last, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input entry_value, input is_last, input status,
                  input occupancy, output ready);
endinterface

// File: hw/rtl/double_ended_queue.sv
// double_ended_queue: bounded deque held in a chain of cells, front entry in cell 0
// results are registered when a command is taken; a readout first enters the read state, which registers its entries
// insert and remove: one command per cycle while results are taken; readout of N entries: one entry per cycle
//   while the receiver takes them, command port held until the chain has rotated back into place
// reset: count and control cleared, cell contents undefined, no clearing pass
// depends on dqe_pkg, dqe_cmd_if, dqe_rsp_if and dqe_cell

module double_ended_queue
  import dqe_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dqe_cmd_if.sink     cmd_i,
  dqe_rsp_if.source   rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            bwd_q, bwd_d;

  logic                    rsp_valid_q, rsp_valid_d;
  logic signed [VAL_W-1:0] rsp_value_q, rsp_value_d;
  logic                    rsp_last_q, rsp_last_d;
  status_e                 rsp_status_q, rsp_status_d;
  logic [OCC_W-1:0]        rsp_occ_q, rsp_occ_d;
  logic                    rsp_load;

  cell_op_e                op;
  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic signed [VAL_W-1:0] cell_tail [DEPTH];
  logic signed [VAL_W-1:0] tail_val;
  logic signed [VAL_W-1:0] wrap_val;
  logic                    out_free;
  logic                    cmd_acc;
  cmd_e                    cmd;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && out_free;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign cmd         = cmd_e'(cmd_i.command);

  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | cell_tail[i];
    end
  end

  assign wrap_val = bwd_q ? tail_val : cell_data[0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    bwd_d        = bwd_q;
    op           = OP_HOLD;
    rsp_load     = 1'b0;
    rsp_value_d  = '0;
    rsp_last_d   = 1'b1;
    rsp_status_d = STS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          rsp_load = 1'b1;
          unique case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (count_q == DepthC) begin
                rsp_status_d = STS_FULL;
              end else begin
                op      = (cmd == CMD_INS_FRONT) ? OP_INS_FRONT : OP_INS_BACK;
                count_d = count_q + 1'b1;
              end
            end
            CMD_REM_FRONT, CMD_REM_BACK: begin
              if (count_q == '0) begin
                rsp_status_d = STS_EMPTY;
              end else begin
                op      = (cmd == CMD_REM_FRONT) ? OP_REM_FRONT : OP_HOLD;
                count_d = count_q - 1'b1;
              end
            end
            CMD_READ_FWD, CMD_READ_BWD: begin
              if (count_q == '0) begin
                rsp_status_d = STS_EMPTY;
              end else begin
                rsp_load = 1'b0;
                state_d  = ST_READ;
                rem_d    = count_q;
                bwd_d    = (cmd == CMD_READ_BWD);
              end
            end
            default: rsp_status_d = STS_OK;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          rsp_load    = 1'b1;
          rsp_value_d = bwd_q ? tail_val : cell_data[0];
          rsp_last_d  = (rem_q == CntW'(1));
          op          = bwd_q ? OP_ROT_BWD : OP_ROT_FWD;
          rem_d       = rem_q - 1'b1;
          if (rem_q == CntW'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    rsp_occ_d = OCC_W'(count_d);
  end

  assign rsp_valid_d = rsp_load || (rsp_valid_q && !rsp_o.ready);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    dqe_cell #(
      .CntW (CntW),
      .Idx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .count_i (count_q),
      .value_i (cmd_i.value),
      .wrap_i  (wrap_val),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .tail_o  (cell_tail[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      bwd_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      bwd_q       <= bwd_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_value_q  <= rsp_value_d;
      rsp_last_q   <= rsp_last_d;
      rsp_status_q <= rsp_status_d;
      rsp_occ_q    <= rsp_occ_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.entry_value = rsp_value_q;
  assign rsp_o.is_last     = rsp_last_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.occupancy   = rsp_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_read_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> rem_q != '0 && rem_q <= count_q)
    else $error("readout counter out of range");

  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !cmd_i.ready && count_q == $past(count_q))
    else $error("command taken or count changed during readout");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && count_q == DepthC && (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK)
    |=> count_q == DepthC && rsp_o.valid && rsp_o.status == STS_FULL)
    else $error("insert into full queue not dropped");

endmodule

// File: hw/rtl/dqe_cell.sv
// dqe_cell: one storage cell of the queue chain, shifts, rotates or loads its entry
// depends on dqe_pkg for cell_op_e and widths

module dqe_cell
  import dqe_pkg::*;
#(
  parameter int unsigned CntW = 6,
  parameter int unsigned Idx  = 0
) (
  input  logic                    clk_i,
  input  cell_op_e                op_i,
  input  logic [CntW-1:0]         count_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic signed [VAL_W-1:0] wrap_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] data_o,
  output logic signed [VAL_W-1:0] tail_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic signed [VAL_W-1:0] data_q, data_d;
  logic                    is_tail;
  logic                    in_use;

  assign is_tail = (IdxC == CntW'(count_i - 1'b1));
  assign in_use  = (IdxC < count_i);

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      OP_HOLD:      data_d = data_q;
      OP_INS_FRONT: data_d = (Idx == 0) ? value_i : left_i;
      OP_INS_BACK:  if (IdxC == count_i) data_d = value_i;
      OP_REM_FRONT: data_d = right_i;
      OP_ROT_FWD:   if (in_use) data_d = is_tail ? wrap_i : right_i;
      OP_ROT_BWD:   if (in_use) data_d = (Idx == 0) ? wrap_i : left_i;
      default:      data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tail_o = is_tail ? data_q : '0;

endmodule

// File: tb/tb_double_ended_queue.sv
// tb_double_ended_queue: self-checking bench for the bounded double-ended queue
// a directed command table, then random fill/drain/mix episodes, checked against a local deque
// depends on dqe_pkg, dqe_cmd_if, dqe_rsp_if and double_ended_queue

module tb_double_ended_queue;
  import dqe_pkg::*;

  localparam int unsigned DEPTH          = 32;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RAND_ITEMS     = 430;
  localparam int unsigned DIR_ROWS       = 23;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned HOLD_AFTER     = DIR_ROWS + 120;
  localparam int unsigned PAUSE_AT       = 250;
  localparam int unsigned DRAIN_LIMIT    = 40000;
  localparam int unsigned DRAIN_CYCLES   = 2 * DEPTH + 8;
  localparam int unsigned TIMEOUT_CYCLES = 2000000;
  localparam int unsigned MAX_REPORTS    = 40;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic                    is_last;
    logic [STS_W-1:0]        status;
    logic [OCC_W-1:0]        occupancy;
  } deque_rsp_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] value;
    bit               typed;
    deque_rsp_t       rsp;
  } cmd_row_t;

  typedef enum int unsigned {
    EP_FILL  = 0,
    EP_DRAIN = 1,
    EP_MIX   = 2
  } episode_e;

  logic clk_i;
  logic rst_ni;

  dqe_cmd_if cmd_if ();
  dqe_rsp_if rsp_if ();

  double_ended_queue #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // local copy of the deque
  logic [VAL_W-1:0] deque_ring [DEPTH];
  int unsigned      front_pos;
  int unsigned      held;

  deque_rsp_t  expected_rsp_q [$];
  int unsigned n_errors;
  int unsigned items_sent;
  int unsigned n_checked;
  int unsigned n_readouts;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned n_pauses;
  bit          long_hold_done;

  cmd_row_t cmd_table [DIR_ROWS] = '{
    '{CMD_READ_FWD,  32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_EMPTY, 6'd0}},
    '{CMD_REM_FRONT, 32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_EMPTY, 6'd0}},
    '{CMD_REM_BACK,  32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_EMPTY, 6'd0}},
    '{CMD_READ_BWD,  32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_EMPTY, 6'd0}},
    '{CMD_SPARE_6,   32'hdead_beef, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd0}},
    '{CMD_SPARE_7,   32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd0}},
    '{CMD_INS_FRONT, 32'h7fff_ffff, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd1}},
    '{CMD_INS_BACK,  32'h8000_0000, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd2}},
    '{CMD_INS_FRONT, 32'hffff_ffff, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd3}},
    '{CMD_INS_BACK,  32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd4}},
    '{CMD_READ_FWD,  32'h0000_0000, 1'b0, '0},
    '{CMD_READ_BWD,  32'h0000_0000, 1'b0, '0},
    '{CMD_SPARE_6,   32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd4}},
    '{CMD_REM_FRONT, 32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd3}},
    '{CMD_REM_BACK,  32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd2}},
    '{CMD_READ_FWD,  32'h0000_0000, 1'b0, '0},
    '{CMD_REM_BACK,  32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd1}},
    '{CMD_READ_BWD,  32'h0000_0000, 1'b0, '0},
    '{CMD_REM_FRONT, 32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd0}},
    '{CMD_REM_BACK,  32'h0000_0000, 1'b1, '{32'sh0, 1'b1, STS_EMPTY, 6'd0}},
    '{CMD_INS_BACK,  32'h5555_5555, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd1}},
    '{CMD_INS_FRONT, 32'haaaa_aaaa, 1'b1, '{32'sh0, 1'b1, STS_OK,    6'd2}},
    '{CMD_READ_FWD,  32'h0000_0000, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                                 output deque_rsp_t res[$]);
    deque_rsp_t  r;
    int unsigned off;
    res = {};
    r = '{entry_value: '0, is_last: 1'b1, status: STS_OK, occupancy: '0};
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (held >= DEPTH) begin
          r.status = STS_FULL;
          n_full++;
        end else begin
          if (cmd == CMD_INS_FRONT) begin
            front_pos = (front_pos + DEPTH - 1) % DEPTH;
            deque_ring[front_pos] = val;
          end else begin
            deque_ring[(front_pos + held) % DEPTH] = val;
          end
          held++;
        end
        r.occupancy = OCC_W'(held);
        res.push_back(r);
      end
      CMD_REM_FRONT, CMD_REM_BACK: begin
        if (held == 0) begin
          r.status = STS_EMPTY;
          n_empty++;
        end else begin
          if (cmd == CMD_REM_FRONT) front_pos = (front_pos + 1) % DEPTH;
          held--;
        end
        r.occupancy = OCC_W'(held);
        res.push_back(r);
      end
      CMD_READ_FWD, CMD_READ_BWD: begin
        n_readouts++;
        r.occupancy = OCC_W'(held);
        if (held == 0) begin
          r.status = STS_EMPTY;
          n_empty++;
          res.push_back(r);
        end else begin
          for (int unsigned i = 0; i < held; i++) begin
            off = (cmd == CMD_READ_FWD) ? i : (held - 1 - i);
            r.entry_value = deque_ring[(front_pos + off) % DEPTH];
            r.is_last     = (i + 1 == held);
            res.push_back(r);
          end
        end
      end
      default: begin
        r.occupancy = OCC_W'(held);
        res.push_back(r);
      end
    endcase
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                              input bit use_typed, input deque_rsp_t typed_rsp);
    deque_rsp_t pred [$];
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.value   <= val;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    items_sent++;
    predict_command(cmd, val, pred);
    if (use_typed) begin
      expected_rsp_q.push_back(typed_rsp);
    end else begin
      foreach (pred[i]) expected_rsp_q.push_back(pred[i]);
    end
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n != 0) begin
      cmd_if.valid   <= 1'b0;
      cmd_if.command <= CMD_W'($urandom());
      cmd_if.value   <= $urandom();
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4:       return VAL_W'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input episode_e ep);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (ep)
      EP_FILL: begin
        if (roll < 40) return CMD_INS_FRONT;
        if (roll < 80) return CMD_INS_BACK;
        if (roll < 86) return CMD_REM_FRONT;
        if (roll < 90) return CMD_REM_BACK;
        if (roll < 95) return CMD_READ_FWD;
        return CMD_READ_BWD;
      end
      EP_DRAIN: begin
        if (roll < 5)  return CMD_INS_FRONT;
        if (roll < 10) return CMD_INS_BACK;
        if (roll < 50) return CMD_REM_FRONT;
        if (roll < 90) return CMD_REM_BACK;
        if (roll < 95) return CMD_READ_FWD;
        return CMD_READ_BWD;
      end
      default: begin
        if (roll < 20) return CMD_INS_FRONT;
        if (roll < 40) return CMD_INS_BACK;
        if (roll < 55) return CMD_REM_FRONT;
        if (roll < 70) return CMD_REM_BACK;
        if (roll < 82) return CMD_READ_FWD;
        if (roll < 94) return CMD_READ_BWD;
        if (roll < 97) return CMD_SPARE_6;
        return CMD_SPARE_7;
      end
    endcase
  endfunction

  task automatic check_result();
    deque_rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: value %0d last %0b status %0d occ %0d",
                                rsp_if.entry_value, rsp_if.is_last, rsp_if.status,
                                rsp_if.occupancy));
      return;
    end
    want = expected_rsp_q.pop_front();
    n_checked++;
    if (rsp_if.entry_value !== want.entry_value)
      report_mismatch($sformatf("entry_value %0d, expected %0d", rsp_if.entry_value,
                                want.entry_value));
    if (rsp_if.is_last !== want.is_last)
      report_mismatch($sformatf("is_last %0b, expected %0b", rsp_if.is_last, want.is_last));
    if (rsp_if.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
    if (rsp_if.occupancy !== want.occupancy)
      report_mismatch($sformatf("occupancy %0d, expected %0d", rsp_if.occupancy,
                                want.occupancy));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_result();
  end

  // receiver backpressure: segments of differing stall patterns plus one long hold
  initial begin : rsp_ready_gen
    int unsigned seg_left;
    int unsigned seg_mode;
    int unsigned phase;
    seg_left = 0;
    seg_mode = 0;
    phase    = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && items_sent >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 64);
        end
        seg_left--;
        phase++;
        case (seg_mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_if.ready <= phase[0];
          default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    episode_e    ep;
    int unsigned ep_left;
    int unsigned burst_left;
    int unsigned waited;
    int unsigned k;
    n_errors       = 0;
    items_sent     = 0;
    n_checked      = 0;
    n_readouts     = 0;
    n_full         = 0;
    n_empty        = 0;
    n_pauses       = 0;
    long_hold_done = 1'b0;
    front_pos      = 0;
    held           = 0;
    rst_ni         <= 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.command <= '0;
    cmd_if.value   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cmd_table[i]) begin
      send_command(cmd_table[i].command, cmd_table[i].value, cmd_table[i].typed,
                   cmd_table[i].rsp);
      idle_cycles($urandom_range(0, 2));
    end

    ep         = EP_FILL;
    ep_left    = 60;
    burst_left = $urandom_range(4, 16);
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == PAUSE_AT) begin
        cmd_if.valid <= 1'b0;
        @(posedge clk_i);
        while (expected_rsp_q.size() != 0) @(posedge clk_i);
        n_pauses++;
      end
      if (ep_left == 0) begin
        ep      = episode_e'($urandom_range(0, 2));
        ep_left = $urandom_range(15, 50);
      end
      ep_left--;
      send_command(pick_command(ep), pick_value(), 1'b0, '0);
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end

    cmd_if.valid <= 1'b0;
    waited = 0;
    while (expected_rsp_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_rsp_q.size()));

    $display("covered %0d commands: %0d readouts, %0d full inserts, %0d empty hits",
             items_sent, n_readouts, n_full, n_empty);
    $display("checked %0d results, receiver hold of %0d cycles, %0d drain pause(s)",
             n_checked, long_hold_done ? LONG_HOLD : 0, n_pauses);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", expected_rsp_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
